// File: design/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and constants for the escaped frame receiver: register map,
// configuration bundle, result bundle and buffer sizing.
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LEN_W;

  // receive buffer depth; usable length is one less than the length setting, saturated at the smaller of this and 256
  localparam int BUF_DEPTH  = 256;
  localparam int LEN_LIMIT  = (BUF_DEPTH < 256) ? BUF_DEPTH : 256;

  localparam int IN_TDATA_W   = 8;
  localparam int OUT_USED_W   = 5 * BYTE_W + 2;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_USED_W;

  localparam logic [BYTE_W-1:0] BEGIN_RST  = 8'd2;
  localparam logic [BYTE_W-1:0] END_RST    = 8'd3;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd16;
  localparam logic [BYTE_W-1:0] EMPTY_RST  = 8'd0;
  localparam logic [LEN_W-1:0]  LEN_RST    = 9'd256;

  // header bytes ahead of the payload
  localparam logic [BYTE_W-1:0] HDR_BYTES  = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BEGIN_MARKER  = 3'd0,
    REG_END_MARKER    = 3'd1,
    REG_ESCAPE_MARKER = 3'd2,
    REG_EMPTY_CMD     = 3'd3,
    REG_EMPTY_ARG     = 3'd4,
    REG_BUFFER_LENGTH = 3'd5
  } efr_reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] begin_marker;
    logic [BYTE_W-1:0] end_marker;
    logic [BYTE_W-1:0] escape_marker;
    logic [BYTE_W-1:0] empty_cmd;
    logic [BYTE_W-1:0] empty_arg;
    logic [LEN_W-1:0]  buffer_length;
  } efr_cfg_t;

  typedef struct packed {
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
    logic              frame_done;
    logic              packet_ready;
    logic [BYTE_W-1:0] packet_cmd;
    logic [BYTE_W-1:0] packet_arg;
    logic [BYTE_W-1:0] packet_count;
    logic              overflow;
  } efr_res_t;

  // number of bytes the buffer may hold for a given length setting
  function automatic logic [LEN_W-1:0] capacity(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] lim;
    lim = (len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : len;
    return (lim == '0) ? '0 : lim - LEN_W'(1);
  endfunction

endpackage

// File: design/efr_cfg_regs.sv
// ----------------------------------------------------------------------------
// efr_cfg_regs
// Configuration register file: marker bytes, empty packet values and buffer
// length, written through a plain write port.
// ----------------------------------------------------------------------------
module efr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [efr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [efr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output efr_pkg::efr_cfg_t              cfg
);
  import efr_pkg::*;

  efr_cfg_t cfg_r;
  efr_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_BEGIN_MARKER:  cfg_nxt.begin_marker  = cfg_wdata[BYTE_W-1:0];
        REG_END_MARKER:    cfg_nxt.end_marker    = cfg_wdata[BYTE_W-1:0];
        REG_ESCAPE_MARKER: cfg_nxt.escape_marker = cfg_wdata[BYTE_W-1:0];
        REG_EMPTY_CMD:     cfg_nxt.empty_cmd     = cfg_wdata[BYTE_W-1:0];
        REG_EMPTY_ARG:     cfg_nxt.empty_arg     = cfg_wdata[BYTE_W-1:0];
        REG_BUFFER_LENGTH: cfg_nxt.buffer_length = cfg_wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.begin_marker  <= BEGIN_RST;
      cfg_r.end_marker    <= END_RST;
      cfg_r.escape_marker <= ESCAPE_RST;
      cfg_r.empty_cmd     <= EMPTY_RST;
      cfg_r.empty_arg     <= EMPTY_RST;
      cfg_r.buffer_length <= LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/efr_core.sv
// ----------------------------------------------------------------------------
// efr_core
// Deframer state and per-byte decode: escape, begin and end marker handling,
// header capture, payload indexing and packet build.
// ----------------------------------------------------------------------------
module efr_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  efr_pkg::efr_cfg_t          cfg,
  input  logic                       step_en,
  input  logic [efr_pkg::BYTE_W-1:0] step_byte,
  output efr_pkg::efr_res_t          res
);
  import efr_pkg::*;

  logic              esc_r, esc_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic [BYTE_W-1:0] byte_count_r, byte_count_nxt;
  logic [BYTE_W-1:0] first_r, first_nxt;
  logic [BYTE_W-1:0] second_r, second_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [BYTE_W-1:0] arg_r, arg_nxt;
  logic [BYTE_W-1:0] count_r, count_nxt;
  logic              ready_r, ready_nxt;
  logic              ovf_r, ovf_nxt;

  logic esc_hit, beg_hit, end_hit, room;

  assign esc_hit = (step_byte == cfg.escape_marker) && !esc_r;
  assign beg_hit = (step_byte == cfg.begin_marker) && !esc_r;
  assign end_hit = (step_byte == cfg.end_marker) && !esc_r;
  assign room    = {1'b0, byte_count_r} < capacity(cfg.buffer_length);

  always_comb begin
    esc_nxt        = esc_r;
    in_frame_nxt   = in_frame_r;
    byte_count_nxt = byte_count_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    cmd_nxt        = cmd_r;
    arg_nxt        = arg_r;
    count_nxt      = count_r;
    ready_nxt      = ready_r;
    ovf_nxt        = ovf_r;
    res.payload_valid = 1'b0;
    res.payload_byte  = '0;
    res.payload_index = '0;
    res.frame_done    = 1'b0;
    if (esc_hit) begin
      esc_nxt = 1'b1;
    end else if (beg_hit) begin
      cmd_nxt        = cfg.empty_cmd;
      arg_nxt        = cfg.empty_arg;
      count_nxt      = '0;
      byte_count_nxt = '0;
      ready_nxt      = 1'b0;
      in_frame_nxt   = 1'b1;
    end else if (end_hit) begin
      if (byte_count_r >= HDR_BYTES) begin
        cmd_nxt   = first_r;
        arg_nxt   = second_r;
        count_nxt = byte_count_r - HDR_BYTES;
      end
      in_frame_nxt   = 1'b0;
      ready_nxt      = 1'b1;
      res.frame_done = 1'b1;
    end else begin
      esc_nxt = 1'b0;
      if (in_frame_r) begin
        if (room) begin
          if (byte_count_r == '0) begin
            first_nxt = step_byte;
          end else if (byte_count_r == BYTE_W'(1)) begin
            second_nxt = step_byte;
          end else begin
            res.payload_valid = 1'b1;
            res.payload_byte  = step_byte;
            res.payload_index = byte_count_r - HDR_BYTES;
          end
          byte_count_nxt = byte_count_r + BYTE_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
    res.packet_ready = ready_nxt;
    res.packet_cmd   = cmd_nxt;
    res.packet_arg   = arg_nxt;
    res.packet_count = count_nxt;
    res.overflow     = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r        <= 1'b0;
      in_frame_r   <= 1'b0;
      byte_count_r <= '0;
      cmd_r        <= EMPTY_RST;
      arg_r        <= EMPTY_RST;
      count_r      <= '0;
      ready_r      <= 1'b0;
      ovf_r        <= 1'b0;
    end else if (step_en) begin
      esc_r        <= esc_nxt;
      in_frame_r   <= in_frame_nxt;
      byte_count_r <= byte_count_nxt;
      cmd_r        <= cmd_nxt;
      arg_r        <= arg_nxt;
      count_r      <= count_nxt;
      ready_r      <= ready_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  // header bytes carry no reset
  always_ff @(posedge clk) begin
    if (step_en) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag dropped");

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && end_hit && !esc_hit && !beg_hit |=> !in_frame_r && ready_r)
    else $error("end marker did not close frame");

  a_begin_opens: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && beg_hit && !esc_hit |=> in_frame_r && byte_count_r == '0 && !ready_r)
    else $error("begin marker did not open frame");

  a_payload_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.payload_valid |-> in_frame_r && !res.frame_done)
    else $error("payload outside a frame");

endmodule

// File: design/escaped_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// escaped_frame_receiver_unit
// Byte-stuffed begin/end frame receiver: one result per received byte with
// payload stream and packet status.
//
//   channel  dir  ports                          contents
//   in       in   in_tvalid/tready/tdata         raw byte
//   out      out  out_tvalid/tready/tdata/tlast  payload and packet status
//   cfg      in   cfg_we/idx/wdata               register writes
//
// One byte per cycle sustained while out_tready stays high; a byte passes from
// input transfer to result through the input register and the result register.
// Decode and state update happen as a byte moves into the result register.
// Synchronous active-low reset clears control state, valid flags and configuration; data registers carry no reset.
// An output stall holds the result register; one byte waits in the input
// register, after which in_tready drops.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [efr_pkg::IN_TDATA_W-1:0]  in_tdata,   // in_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // payload_byte, payload_index, packet_ready, packet_cmd, packet_arg,
  // packet_count, overflow, zero pad
  output logic [efr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,  // frame_done
  output logic                            out_tuser,  // payload_valid
  input  logic                            cfg_we,
  input  logic [efr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [efr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import efr_pkg::*;

  efr_cfg_t          cfg;
  efr_res_t          res;
  efr_res_t          out_res_r;
  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_valid_r, out_valid_nxt;
  logic              fire;

  efr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  efr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step_en   (fire),
    .step_byte (in_byte_r),
    .res       (res)
  );

  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata[BYTE_W-1:0];
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.payload_valid;
  assign out_tlast  = out_res_r.frame_done;
  assign out_tdata  = {{OUT_PAD_W{1'b0}},
                       out_res_r.overflow,
                       out_res_r.packet_count,
                       out_res_r.packet_arg,
                       out_res_r.packet_cmd,
                       out_res_r.packet_ready,
                       out_res_r.payload_index,
                       out_res_r.payload_byte};

endmodule
